// ===== hdl/spt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the shaft PID torque controller.
// No dependencies; imported by every module of the block.
package spt_pkg;

    localparam int unsigned W_Q    = 32;
    localparam int unsigned FRAC   = 16;
    localparam int unsigned W_INT  = 48;
    localparam int unsigned W_ERR  = 49;
    localparam int unsigned W_ISUM = 50;
    localparam int unsigned W_ACC  = 64;
    localparam int unsigned W_MOP  = 33;
    localparam int unsigned W_PROD = 2 * W_MOP;
    localparam int unsigned W_STEP = 4;
    localparam int unsigned W_CIDX = 3;

    localparam logic signed [W_ERR-1:0] HALF_PI = 49'sd102944;
    localparam logic signed [W_ERR-1:0] TWO_PI  = 49'sd411775;

    localparam logic signed [W_ACC-1:0] ACC_INT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [W_ACC-1:0] ACC_INT_LO = 64'shFFFF_8000_0000_0000;
    localparam logic signed [W_ACC-1:0] ACC_Q_HI   = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [W_ACC-1:0] ACC_Q_LO   = 64'shFFFF_FFFF_8000_0000;

    localparam logic [W_STEP-1:0] STEP_OPEN = 4'd14;

    typedef enum logic [W_CIDX-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INTEGRAL_GAIN = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_TORQUE_MAX    = 3'd3,
        REG_TORQUE_MIN    = 3'd4,
        REG_GEAR_RATIO    = 3'd5,
        REG_OUTPUT_SCALE  = 3'd6,
        REG_CLOSED_LOOP   = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        MS_NONE,
        MS_TA_GEAR,
        MS_TS_GEAR,
        MS_EA_KP,
        MS_IH_KI,
        MS_IL_KI,
        MS_ES_KD,
        MS_SH_OS,
        MS_SL_OS,
        MS_OL_OS
    } t_mul_sel;

    typedef enum logic [3:0] {
        AO_NONE,
        AO_EA,
        AO_ES,
        AO_INTEG,
        AO_ACC_SET,
        AO_ACC_SET_SHR,
        AO_ACC_ADD,
        AO_ACC_ADD_SHR,
        AO_SAT,
        AO_LIMIT,
        AO_OPEN
    } t_alu_op;

    typedef enum logic {
        JC_NONE,
        JC_OPEN
    } t_jump_cond;

    typedef struct packed {
        t_mul_sel          mul_sel;
        t_alu_op           alu_op;
        t_jump_cond        jump_cond;
        logic [W_STEP-1:0] target;
        logic              done;
    } t_uword;

    typedef struct packed {
        t_uword uw;
        logic   fire;
        logic   load;
    } t_dp_ctrl;

endpackage

// ===== hdl/spt_ucode_rom.sv =====
`timescale 1ns / 1ps
// Control store: one microcode word per program step.
// Depends on spt_pkg.
module spt_ucode_rom
    import spt_pkg::*;
(
    input  logic [W_STEP-1:0] i_step,
    output t_uword            o_uword
);

    always_comb begin
        case (i_step)
            4'd0:    o_uword = '{MS_TA_GEAR, AO_NONE,        JC_OPEN, STEP_OPEN, 1'b0};
            4'd1:    o_uword = '{MS_TS_GEAR, AO_EA,          JC_NONE, '0,        1'b0};
            4'd2:    o_uword = '{MS_NONE,    AO_ES,          JC_NONE, '0,        1'b0};
            4'd3:    o_uword = '{MS_NONE,    AO_INTEG,       JC_NONE, '0,        1'b0};
            4'd4:    o_uword = '{MS_EA_KP,   AO_NONE,        JC_NONE, '0,        1'b0};
            4'd5:    o_uword = '{MS_IH_KI,   AO_ACC_SET_SHR, JC_NONE, '0,        1'b0};
            4'd6:    o_uword = '{MS_IL_KI,   AO_ACC_ADD,     JC_NONE, '0,        1'b0};
            4'd7:    o_uword = '{MS_ES_KD,   AO_ACC_ADD_SHR, JC_NONE, '0,        1'b0};
            4'd8:    o_uword = '{MS_NONE,    AO_ACC_ADD_SHR, JC_NONE, '0,        1'b0};
            4'd9:    o_uword = '{MS_NONE,    AO_SAT,         JC_NONE, '0,        1'b0};
            4'd10:   o_uword = '{MS_SH_OS,   AO_NONE,        JC_NONE, '0,        1'b0};
            4'd11:   o_uword = '{MS_SL_OS,   AO_ACC_SET,     JC_NONE, '0,        1'b0};
            4'd12:   o_uword = '{MS_NONE,    AO_ACC_ADD_SHR, JC_NONE, '0,        1'b0};
            4'd13:   o_uword = '{MS_NONE,    AO_LIMIT,       JC_NONE, '0,        1'b1};
            4'd14:   o_uword = '{MS_OL_OS,   AO_NONE,        JC_NONE, '0,        1'b0};
            4'd15:   o_uword = '{MS_NONE,    AO_OPEN,        JC_NONE, '0,        1'b1};
            default: o_uword = '{MS_NONE,    AO_NONE,        JC_NONE, '0,        1'b1};
        endcase
    end

endmodule

// ===== hdl/spt_sequencer.sv =====
`timescale 1ns / 1ps
// Step counter, jumps and word handshakes of the torque controller.
// Depends on spt_pkg and the word fetched from spt_ucode_rom.
module spt_sequencer
    import spt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  logic              i_closed_loop,
    input  t_uword            i_uword,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output logic [W_STEP-1:0] o_step,
    output t_dp_ctrl          o_ctrl
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_seq_state;

    t_seq_state        r_state, n_state;
    logic [W_STEP-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;
    logic              w_fire;
    logic              w_jump;

    assign w_jump = (i_uword.jump_cond == JC_OPEN) && !i_closed_loop;
    assign w_fire = (r_state == ST_RUN) && (!i_uword.done || !r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                if (w_fire) begin
                    if (i_uword.done) begin
                        n_state     = ST_IDLE;
                        n_out_valid = 1'b1;
                    end else if (w_jump) begin
                        n_step = i_uword.target;
                    end else begin
                        n_step = r_step + W_STEP'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_step       = r_step;
    assign o_ctrl.uw    = i_uword;
    assign o_ctrl.fire  = w_fire;
    assign o_ctrl.load  = i_in_valid && (r_state == ST_IDLE);

endmodule

// ===== hdl/spt_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: configuration registers, shared 33x33 multiplier, accumulator,
// integral state and output word. Depends on spt_pkg; driven by spt_sequencer.
module spt_datapath
    import spt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [W_CIDX-1:0]       i_cfg_addr,
    input  logic [W_Q-1:0]          i_cfg_data,
    input  t_dp_ctrl                i_ctrl,
    input  logic signed [W_Q-1:0]   i_target_angle,
    input  logic signed [W_Q-1:0]   i_target_speed,
    input  logic signed [W_Q-1:0]   i_measured_angle,
    input  logic signed [W_Q-1:0]   i_measured_speed,
    input  logic signed [W_Q-1:0]   i_open_loop_torque,
    output logic                    o_closed_loop,
    output logic signed [W_Q-1:0]   o_drive_torque,
    output logic                    o_limited
);

    logic signed [W_Q-1:0]    r_kp, r_ki, r_kd, r_tmax, r_tmin, r_gear, r_oscale;
    logic                     r_closed;
    logic signed [W_INT-1:0]  r_integ, n_integ;

    logic signed [W_Q-1:0]    r_ta, r_ts, r_ma, r_ms, r_ol;
    logic signed [W_MOP-1:0]  w_mul_a, w_mul_b;
    logic signed [W_PROD-1:0] r_prod;
    logic signed [W_ACC-1:0]  w_prod_shr, w_prod_full;
    logic signed [W_ERR-1:0]  r_ea, r_es;
    logic signed [W_ISUM-1:0] w_isum;
    logic signed [W_ACC-1:0]  r_acc;
    logic signed [W_INT-1:0]  r_sum;
    logic signed [W_ACC-1:0]  w_lim_a, w_lim_b, w_open_t;
    logic                     w_lim_hi, w_lim_lo, w_open_lim;
    logic signed [W_Q-1:0]    r_torque;
    logic                     r_limited;

    function automatic logic signed [W_INT-1:0] sat_int(input logic signed [W_ACC-1:0] v);
        logic signed [W_ACC-1:0] t;
        t = (v > ACC_INT_HI) ? ACC_INT_HI : ((v < ACC_INT_LO) ? ACC_INT_LO : v);
        return t[W_INT-1:0];
    endfunction

    function automatic logic signed [W_ERR-1:0] clamp_err(input logic signed [W_ERR-1:0] v,
                                                          input logic signed [W_ERR-1:0] lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    always_comb begin
        case (i_ctrl.uw.mul_sel)
            MS_TA_GEAR: begin
                w_mul_a = W_MOP'(r_ta);
                w_mul_b = W_MOP'(r_gear);
            end
            MS_TS_GEAR: begin
                w_mul_a = W_MOP'(r_ts);
                w_mul_b = W_MOP'(r_gear);
            end
            MS_EA_KP: begin
                w_mul_a = r_ea[W_MOP-1:0];
                w_mul_b = W_MOP'(r_kp);
            end
            MS_IH_KI: begin
                w_mul_a = W_MOP'($signed(r_integ[W_INT-1:FRAC]));
                w_mul_b = W_MOP'(r_ki);
            end
            MS_IL_KI: begin
                w_mul_a = {{(W_MOP-FRAC){1'b0}}, r_integ[FRAC-1:0]};
                w_mul_b = W_MOP'(r_ki);
            end
            MS_ES_KD: begin
                w_mul_a = r_es[W_MOP-1:0];
                w_mul_b = W_MOP'(r_kd);
            end
            MS_SH_OS: begin
                w_mul_a = W_MOP'($signed(r_sum[W_INT-1:FRAC]));
                w_mul_b = W_MOP'(r_oscale);
            end
            MS_SL_OS: begin
                w_mul_a = {{(W_MOP-FRAC){1'b0}}, r_sum[FRAC-1:0]};
                w_mul_b = W_MOP'(r_oscale);
            end
            MS_OL_OS: begin
                w_mul_a = W_MOP'(r_ol);
                w_mul_b = W_MOP'(r_oscale);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod_shr  = W_ACC'(r_prod >>> FRAC);
    assign w_prod_full = r_prod[W_ACC-1:0];
    assign w_isum      = W_ISUM'(r_integ) + W_ISUM'(r_ea);

    assign w_lim_hi = r_acc > W_ACC'(r_tmax);
    assign w_lim_a  = w_lim_hi ? W_ACC'(r_tmax) : r_acc;
    assign w_lim_lo = w_lim_a < W_ACC'(r_tmin);
    assign w_lim_b  = w_lim_lo ? W_ACC'(r_tmin) : w_lim_a;

    assign w_open_t   = (w_prod_shr > ACC_Q_HI) ? ACC_Q_HI
                      : ((w_prod_shr < ACC_Q_LO) ? ACC_Q_LO : w_prod_shr);
    assign w_open_lim = (w_prod_shr > ACC_Q_HI) || (w_prod_shr < ACC_Q_LO);

    always_comb begin
        n_integ = r_integ;
        if (i_ctrl.fire && (i_ctrl.uw.alu_op == AO_INTEG)) begin
            n_integ = sat_int(W_ACC'(w_isum));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= '0;
            r_ki     <= '0;
            r_kd     <= '0;
            r_tmax   <= '0;
            r_tmin   <= '0;
            r_gear   <= 32'sd65536;
            r_oscale <= 32'sd65536;
            r_closed <= 1'b0;
            r_integ  <= '0;
        end else begin
            r_integ <= n_integ;
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    REG_PROP_GAIN:     r_kp     <= i_cfg_data;
                    REG_INTEGRAL_GAIN: r_ki     <= i_cfg_data;
                    REG_DERIV_GAIN:    r_kd     <= i_cfg_data;
                    REG_TORQUE_MAX:    r_tmax   <= i_cfg_data;
                    REG_TORQUE_MIN:    r_tmin   <= i_cfg_data;
                    REG_GEAR_RATIO:    r_gear   <= i_cfg_data;
                    REG_OUTPUT_SCALE:  r_oscale <= i_cfg_data;
                    REG_CLOSED_LOOP:   r_closed <= i_cfg_data[0];
                    default:           r_closed <= r_closed;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ta <= i_target_angle;
            r_ts <= i_target_speed;
            r_ma <= i_measured_angle;
            r_ms <= i_measured_speed;
            r_ol <= i_open_loop_torque;
        end
        if (i_ctrl.fire) begin
            r_prod <= w_mul_a * w_mul_b;
            case (i_ctrl.uw.alu_op)
                AO_EA: begin
                    r_ea <= w_prod_shr[W_ERR-1:0] - W_ERR'(r_ma);
                end
                AO_ES: begin
                    r_es <= w_prod_shr[W_ERR-1:0] - W_ERR'(r_ms);
                end
                AO_INTEG: begin
                    r_ea <= clamp_err(r_ea, HALF_PI);
                    r_es <= clamp_err(r_es, TWO_PI);
                end
                AO_ACC_SET:     r_acc <= w_prod_full;
                AO_ACC_SET_SHR: r_acc <= w_prod_shr;
                AO_ACC_ADD:     r_acc <= r_acc + w_prod_full;
                AO_ACC_ADD_SHR: r_acc <= r_acc + w_prod_shr;
                AO_SAT:         r_sum <= sat_int(r_acc);
                AO_LIMIT: begin
                    r_torque  <= w_lim_b[W_Q-1:0];
                    r_limited <= w_lim_hi || w_lim_lo;
                end
                AO_OPEN: begin
                    r_torque  <= w_open_t[W_Q-1:0];
                    r_limited <= w_open_lim;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_closed_loop  = r_closed;
    assign o_drive_torque = r_torque;
    assign o_limited      = r_limited;

endmodule

// ===== hdl/shaft_pid_torque_control.sv =====
`timescale 1ns / 1ps
// Shaft PID torque controller, signed Q16.16, with torque limits.
// Input words carry target and measured angle and speed plus an open-loop
// torque; each yields one output word of drive torque and a limited flag.
// Both channels use valid/ready; a word moves when valid and ready are high.
// Gains, limits, gear ratio, output scale and mode are set on the
// configuration port (enable, index, data); the user must write them only
// while no word is in flight, as the block itself does not enforce this.
// One word is worked at a time: no new input word is taken until the
// program of the last one ends. The microcode program shares one 33x33
// multiplier over the eight products of a closed-loop sample and the two
// of an open-loop sample, one product per step. A finished word waits in
// the output register; the next input word is taken meanwhile, and the
// program holds on its last step while the receiver stalls. Synchronous
// active-low reset clears the program counter, the output valid, the
// integral and the configuration registers to their defaults.
module shaft_pid_torque_control
    import spt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [W_CIDX-1:0]     i_cfg_addr,
    input  logic [W_Q-1:0]        i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic signed [W_Q-1:0] i_target_angle,
    input  logic signed [W_Q-1:0] i_target_speed,
    input  logic signed [W_Q-1:0] i_measured_angle,
    input  logic signed [W_Q-1:0] i_measured_speed,
    input  logic signed [W_Q-1:0] i_open_loop_torque,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [W_Q-1:0] o_drive_torque,
    output logic                  o_limited
);

    logic [W_STEP-1:0] w_step;
    t_uword            w_uword;
    t_dp_ctrl          w_ctrl;
    logic              w_closed;

    spt_ucode_rom u_rom (
        .i_step  (w_step),
        .o_uword (w_uword)
    );

    spt_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_out_ready   (i_out_ready),
        .i_closed_loop (w_closed),
        .i_uword       (w_uword),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_step        (w_step),
        .o_ctrl        (w_ctrl)
    );

    spt_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_addr         (i_cfg_addr),
        .i_cfg_data         (i_cfg_data),
        .i_ctrl             (w_ctrl),
        .i_target_angle     (i_target_angle),
        .i_target_speed     (i_target_speed),
        .i_measured_angle   (i_measured_angle),
        .i_measured_speed   (i_measured_speed),
        .i_open_loop_torque (i_open_loop_torque),
        .o_closed_loop      (w_closed),
        .o_drive_torque     (o_drive_torque),
        .o_limited          (o_limited)
    );

endmodule

// ===== hdl/spt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the torque controller, bound to the top level.
// Depends on spt_pkg and shaft_pid_torque_control.
module spt_checker
    import spt_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [W_Q-1:0] o_drive_torque,
    input logic                  o_limited
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_drive_torque) && $stable(o_limited))
        else $error("output word changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready while a word is in flight");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !$rose(o_out_valid))
        else $error("result appeared one cycle after acceptance");

endmodule

bind shaft_pid_torque_control spt_checker u_spt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_drive_torque (o_drive_torque),
    .o_limited      (o_limited)
);
